FILE: hdl/text_stream_visible_formatter_top_defines.svh
// Assertion macros shared by the formatter top level.
`ifndef TEXT_STREAM_VISIBLE_FORMATTER_TOP_DEFINES_SVH
`define TEXT_STREAM_VISIBLE_FORMATTER_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define TSVF_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a cause is followed by an effect in the next cycle.
`define TSVF_ASSERT_NEXT(label, cause, effect, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error(msg);

`endif

FILE: hdl/tsvf_pkg.sv
`default_nettype none
package tsvf_pkg;

	// One input transaction
	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} item_t;

	// One output transaction
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} result_t;

	// Option registers
	typedef struct packed {
		logic number_all_lines;
		logic number_nonblank_lines;
		logic show_line_ends;
		logic show_tabs;
		logic show_nonprinting;
		logic squeeze_blank;
	} cfg_t;

	// Register indexes
	localparam logic [2:0] REG_NUMBER_ALL      = 3'd0;
	localparam logic [2:0] REG_NUMBER_NONBLANK = 3'd1;
	localparam logic [2:0] REG_SHOW_ENDS       = 3'd2;
	localparam logic [2:0] REG_SHOW_TABS       = 3'd3;
	localparam logic [2:0] REG_SHOW_NONPRINT   = 3'd4;
	localparam logic [2:0] REG_SQUEEZE         = 3'd5;

	// Most bytes that one input byte expands to, number prefix aside
	localparam int unsigned TAIL_MAX = 4;

	// Classified byte handed from front to back
	typedef struct packed {
		logic                      has_num;
		logic [1:0]                tail_last;
		logic [TAIL_MAX-1:0][7:0]  tail;
	} job_t;

	// Character codes
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CARET_FLIP = 8'h40;

	// Newline run saturation
	localparam logic [1:0] RUN_SAT = 2'd3;

endpackage
`default_nettype wire

FILE: hdl/text_stream_visible_formatter_top.sv
// Visible-form text formatter: line numbers, blank-line squeezing, visible
// line ends, tabs, control and high bytes.
// Input channel: a queue write port. A byte transaction is taken when push
// is high and full is low; file_start marks the first byte of each file.
// Result channel: a queue read port. The oldest output byte stands on result
// while empty is low and is taken when pop is high; last_of_run marks the
// final byte produced for one input byte. A squeezed newline produces none.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write options only while the block is idle.
// On an idle block the first result byte of an input byte is written to the
// queue and then to the output register before it stands on result. The back
// part emits one byte per cycle while the output register is free or popped;
// an input byte expands to 1 to NUMBER_DIGITS+5 bytes, none for a squeezed newline.
// A QUEUE_DEPTH entry queue lies between classification and output, so input
// keeps flowing while a result waits.
// When pop stays low, the queue fills and full rises. Reset clears the queue,
// the output valid flag, the options and the line counter.
`default_nettype none
`include "text_stream_visible_formatter_top_defines.svh"
module text_stream_visible_formatter_top #(
	parameter int unsigned NUMBER_DIGITS = 6,
	parameter int unsigned QUEUE_DEPTH   = 4
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	output logic               full,
	input  tsvf_pkg::item_t    item,
	output logic               empty,
	input  wire                pop,
	output tsvf_pkg::result_t  result,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire  [2:0]         cfg_index,
	input  wire                cfg_data
);
	import tsvf_pkg::*;

	localparam int unsigned BW = 4 * NUMBER_DIGITS;
	localparam int unsigned QW = $bits(job_t) + BW;

	logic          take;
	job_t          front_job;
	logic [BW-1:0] front_bcd;
	logic          q_push;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;
	logic [QW-1:0] q_rdata;
	job_t          head_job;
	logic [BW-1:0] head_bcd;

	assign take      = push && !full;
	assign full      = q_full;
	assign cfg_ready = 1'b1;

	tsvf_front #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.take      (take),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.job       (front_job),
		.job_bcd   (front_bcd),
		.job_push  (q_push)
	);

	tsvf_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({front_job, front_bcd}),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign head_job = q_rdata[QW-1 -: $bits(job_t)];
	assign head_bcd = q_rdata[BW-1:0];

	tsvf_back #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_empty),
		.head_job   (head_job),
		.head_bcd   (head_bcd),
		.head_pop   (q_pop),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

	// The queue cannot report full and empty at once
	`TSVF_ASSERT_ALWAYS(a_queue_sane, !(q_full && q_empty), "queue both full and empty")
	// A transaction written to the queue is waiting there next cycle
	`TSVF_ASSERT_NEXT(a_push_lands, q_push, !q_empty, "pushed transaction missing")
	// A popped byte that is not last is followed at once by the next one
	`TSVF_ASSERT_NEXT(a_run_continues, pop && !empty && !result.last_of_run, !empty,
		"output run broken")

endmodule
`default_nettype wire

FILE: hdl/tsvf_front.sv
`default_nettype none
module tsvf_front #(
	parameter int unsigned NUMBER_DIGITS = 6
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  tsvf_pkg::item_t              item,
	input  wire                          take,
	input  wire                          cfg_valid,
	input  wire  [2:0]                   cfg_index,
	input  wire                          cfg_data,
	output tsvf_pkg::job_t               job,
	output logic [4*NUMBER_DIGITS-1:0]   job_bcd,
	output logic                         job_push
);
	import tsvf_pkg::*;

	localparam int unsigned BW = 4 * NUMBER_DIGITS;

	cfg_t          cfg_q;
	logic [BW-1:0] bcd_q;
	logic          at_line_start_q;
	logic [1:0]    newline_run_q;

	logic          nl;
	logic [1:0]    run_base;
	logic [1:0]    run_next;
	logic          drop;
	logic          number;
	logic          all_nines;
	logic [BW-1:0] bcd_inc;
	logic [BW-1:0] bcd_next;
	logic [6:0]    low;
	logic          printable;
	logic          low_caret;
	logic [7:0]    low_flip;

	// Classify the byte and advance the newline run
	always_comb begin
		nl       = (item.data_byte == CH_NL);
		run_base = item.file_start ? 2'd1 : newline_run_q;
		if (nl) begin
			run_next = (run_base == RUN_SAT) ? RUN_SAT : run_base + 2'd1;
		end else begin
			run_next = 2'd0;
		end
		drop = nl && cfg_q.squeeze_blank && (run_next == RUN_SAT);
		if (cfg_q.number_nonblank_lines) begin
			number = at_line_start_q && !nl;
		end else begin
			number = at_line_start_q && cfg_q.number_all_lines;
		end
	end

	// Saturating decimal increment of the line counter
	always_comb begin
		logic       carry;
		logic [3:0] d;
		carry     = 1'b1;
		all_nines = 1'b1;
		bcd_inc   = bcd_q;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			d         = bcd_q[4*i +: 4];
			all_nines = all_nines && (d == 4'd9);
			if (carry) begin
				if (d >= 4'd9) begin
					bcd_inc[4*i +: 4] = 4'd0;
				end else begin
					bcd_inc[4*i +: 4] = d + 4'd1;
					carry             = 1'b0;
				end
			end
		end
		bcd_next = (number && !all_nines) ? bcd_inc : bcd_q;
	end

	// Build the visible form of the byte
	always_comb begin
		low       = item.data_byte[6:0];
		printable = ({1'b0, low} inside {[8'd32:8'd126]});
		low_caret = cfg_q.show_nonprinting && !printable;
		low_flip  = {1'b0, low} ^ CARET_FLIP;
		job.has_num   = number;
		job.tail      = '0;
		job.tail_last = 2'd0;
		if (nl) begin
			if (cfg_q.show_line_ends) begin
				job.tail[0]   = CH_DOLLAR;
				job.tail[1]   = CH_NL;
				job.tail_last = 2'd1;
			end else begin
				job.tail[0] = CH_NL;
			end
		end else if (item.data_byte == CH_TAB) begin
			if (cfg_q.show_tabs) begin
				job.tail[0]   = CH_CARET;
				job.tail[1]   = CH_I;
				job.tail_last = 2'd1;
			end else begin
				job.tail[0] = CH_TAB;
			end
		end else if (!item.data_byte[7]) begin
			if (low_caret) begin
				job.tail[0]   = CH_CARET;
				job.tail[1]   = low_flip;
				job.tail_last = 2'd1;
			end else begin
				job.tail[0] = item.data_byte;
			end
		end else if (cfg_q.show_nonprinting) begin
			job.tail[0] = CH_M;
			job.tail[1] = CH_DASH;
			if (low_caret) begin
				job.tail[2]   = CH_CARET;
				job.tail[3]   = low_flip;
				job.tail_last = 2'd3;
			end else begin
				job.tail[2]   = {1'b0, low};
				job.tail_last = 2'd2;
			end
		end else begin
			job.tail[0] = item.data_byte;
		end
	end

	assign job_bcd  = bcd_next;
	assign job_push = take && !drop;

	// Hold line state; advance it on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_q           <= '0;
			at_line_start_q <= 1'b1;
			newline_run_q   <= 2'd1;
		end else if (take) begin
			at_line_start_q <= nl;
			newline_run_q   <= run_next;
			if (!drop) begin
				bcd_q <= bcd_next;
			end
		end
	end

	// Write option registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_NUMBER_ALL:      cfg_q.number_all_lines      <= cfg_data;
				REG_NUMBER_NONBLANK: cfg_q.number_nonblank_lines <= cfg_data;
				REG_SHOW_ENDS:       cfg_q.show_line_ends        <= cfg_data;
				REG_SHOW_TABS:       cfg_q.show_tabs             <= cfg_data;
				REG_SHOW_NONPRINT:   cfg_q.show_nonprinting      <= cfg_data;
				REG_SQUEEZE:         cfg_q.squeeze_blank         <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hdl/tsvf_queue.sv
`default_nettype none
module tsvf_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire  [WIDTH-1:0] wdata,
	output logic             full,
	input  wire              pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rd_ptr_q];

	// Write the entry at the tail
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/tsvf_back.sv
`default_nettype none
module tsvf_back #(
	parameter int unsigned NUMBER_DIGITS = 6
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         head_valid,
	input  tsvf_pkg::job_t              head_job,
	input  wire  [4*NUMBER_DIGITS-1:0]  head_bcd,
	output logic                        head_pop,
	input  wire                         pop,
	output logic                        empty,
	output tsvf_pkg::result_t           result
);
	import tsvf_pkg::*;

	localparam int unsigned BW = 4 * NUMBER_DIGITS;
	localparam int unsigned PW = $clog2(NUMBER_DIGITS + 5);
	localparam logic [PW-1:0] POS_LEAD = PW'(NUMBER_DIGITS - 1);
	localparam logic [PW-1:0] POS_TAB  = PW'(NUMBER_DIGITS);
	localparam logic [PW-1:0] POS_TAIL = PW'(NUMBER_DIGITS + 1);

	logic          started_q;
	logic [PW-1:0] pos_q;
	logic [BW-1:0] num_q;
	logic          seen_q;
	logic          out_valid_q;
	result_t       out_q;

	logic [PW-1:0] cur_pos;
	logic [BW-1:0] cur_num;
	logic          cur_seen;
	logic [3:0]    digit;
	logic          seen_next;
	logic [PW-1:0] tail_off;
	logic [1:0]    tail_idx;
	logic [7:0]    byte_sel;
	logic          is_last;
	logic          emit;

	// Pick the next byte of the head transaction
	always_comb begin
		cur_pos   = started_q ? pos_q : (head_job.has_num ? '0 : POS_TAIL);
		cur_num   = started_q ? num_q : head_bcd;
		cur_seen  = started_q && seen_q;
		digit     = cur_num[BW-1 -: 4];
		seen_next = cur_seen || (digit != 4'd0) || (cur_pos == POS_LEAD);
		tail_off  = cur_pos - POS_TAIL;
		tail_idx  = tail_off[1:0];
		is_last   = 1'b0;
		if (cur_pos < POS_TAB) begin
			byte_sel = seen_next ? 8'(CH_ZERO + {4'd0, digit}) : CH_SPACE;
		end else if (cur_pos == POS_TAB) begin
			byte_sel = CH_TAB;
		end else begin
			byte_sel = head_job.tail[tail_idx];
			is_last  = (tail_idx == head_job.tail_last);
		end
	end

	assign emit     = head_valid && (!out_valid_q || pop);
	assign head_pop = emit && is_last;
	assign empty    = !out_valid_q;
	assign result   = out_q;

	// Advance within the head transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			pos_q     <= '0;
			seen_q    <= 1'b0;
		end else if (emit) begin
			started_q <= !is_last;
			pos_q     <= cur_pos + 1'b1;
			seen_q    <= seen_next;
		end
	end

	// Shift digits out, most significant first
	always_ff @(posedge clk) begin
		if (emit) begin
			num_q <= cur_num << 4;
		end
	end

	// Hold the result until it is popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_byte    <= byte_sel;
			out_q.last_of_run <= is_last;
		end
	end

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import tsvf_pkg::*;

	localparam int DIGITS         = 6;
	localparam int HALF_PERIOD    = 6;
	localparam int DRAIN_CYCLES   = 10;
	localparam int TAIL_CYCLES    = 20;
	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 9;
	localparam int PHASE_ITEMS    = 34;

	// Option settings used by the directed table and the random phases
	localparam cfg_t C_PLAIN    = 6'b000000;
	localparam cfg_t C_SHOW     = 6'b101111;
	localparam cfg_t C_NONBLANK = 6'b110000;
	localparam cfg_t C_ALL_ON   = 6'b111111;
	localparam cfg_t C_COUNT    = 6'b101000;

	// One row of directed stimulus; want is used only when typed is set
	typedef struct packed {
		cfg_t       opts;
		item_t      stim;
		logic       typed;
		logic [7:0] want;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	item_t      item;
	logic       empty;
	logic       pop;
	result_t    result;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic       cfg_data;

	// Predictor state
	logic [4*DIGITS-1:0] pred_line_bcd;
	logic                pred_at_line_start;
	logic [1:0]          pred_nl_run;
	cfg_t                pred_opts;
	logic [7:0]          formatted[$];

	result_t   expected_out[$];
	stim_row_t dir_rows[$];

	int  errors;
	int  n_items;
	int  n_results;
	int  n_settings;
	int  stall_cycles;
	bit  sender_steady;
	bit  receiver_steady;
	bit  hold_wanted;

	text_stream_visible_formatter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Append the visible form of a byte below 128 that is not tab or newline
	function automatic void caret_form(input logic [7:0] c);
		if ((c >= 8'd32 && c <= 8'd126) || !pred_opts.show_nonprinting) begin
			formatted.push_back(c);
		end else begin
			formatted.push_back(CH_CARET);
			formatted.push_back(c ^ CARET_FLIP);
		end
	endfunction

	// Compute the output bytes for one input byte and advance the line state
	function automatic void format_byte(input item_t it);
		logic [7:0] b;
		logic [7:0] ch;
		logic [3:0] d;
		logic       nl;
		logic       numbered;
		logic       seen;
		logic       done;
		int         i;
		b = it.data_byte;
		nl = (b == CH_NL);
		formatted.delete();
		if (it.file_start)
			pred_nl_run = 2'd1;
		if (nl) begin
			if (pred_nl_run < RUN_SAT)
				pred_nl_run = pred_nl_run + 2'd1;
		end else begin
			pred_nl_run = 2'd0;
		end
		// Drop a newline that would open a second blank line
		if (nl && pred_opts.squeeze_blank && pred_nl_run == RUN_SAT) begin
			pred_at_line_start = 1'b1;
			return;
		end
		if (pred_opts.number_nonblank_lines)
			numbered = pred_at_line_start && !nl;
		else
			numbered = pred_at_line_start && pred_opts.number_all_lines;
		if (numbered) begin
			// Count up in decimal, holding at all nines
			if (pred_line_bcd != {DIGITS{4'h9}}) begin
				done = 1'b0;
				for (i = 0; i < DIGITS; i++) begin
					if (!done) begin
						d = pred_line_bcd[4*i +: 4];
						if (d >= 4'd9) begin
							pred_line_bcd[4*i +: 4] = 4'd0;
						end else begin
							pred_line_bcd[4*i +: 4] = d + 4'd1;
							done = 1'b1;
						end
					end
				end
			end
			// Right-aligned number, blanks for leading zeros, then a tab
			seen = 1'b0;
			for (i = DIGITS - 1; i >= 0; i--) begin
				d = pred_line_bcd[4*i +: 4];
				if (d != 4'd0 || i == 0)
					seen = 1'b1;
				ch = seen ? CH_ZERO + {4'h0, d} : CH_SPACE;
				formatted.push_back(ch);
			end
			formatted.push_back(CH_TAB);
		end
		if (nl) begin
			if (pred_opts.show_line_ends)
				formatted.push_back(CH_DOLLAR);
			formatted.push_back(b);
		end else if (b == CH_TAB) begin
			if (pred_opts.show_tabs) begin
				formatted.push_back(CH_CARET);
				formatted.push_back(CH_I);
			end else begin
				formatted.push_back(b);
			end
		end else if (!b[7]) begin
			caret_form(b);
		end else if (pred_opts.show_nonprinting) begin
			formatted.push_back(CH_M);
			formatted.push_back(CH_DASH);
			caret_form({1'b0, b[6:0]});
		end else begin
			formatted.push_back(b);
		end
		pred_at_line_start = nl;
	endfunction

	// Mostly short gaps, now and then a long one, none in a steady stretch
	function automatic int pick_gap(input bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// Random text: newlines at the given rate, some tabs, controls and high bytes
	function automatic item_t random_text_byte(input int nl_pct);
		item_t it;
		int    r;
		int    c;
		r = $urandom_range(0, 99);
		if (r < nl_pct) begin
			it.data_byte = CH_NL;
		end else if (r < nl_pct + 6) begin
			it.data_byte = CH_TAB;
		end else if (r < nl_pct + 16) begin
			c = $urandom_range(0, 32);
			it.data_byte = (c == 32) ? 8'h7F : 8'(c);
		end else if (r < nl_pct + 28) begin
			it.data_byte = 8'($urandom_range(128, 255));
		end else begin
			it.data_byte = 8'($urandom_range(32, 126));
		end
		it.file_start = ($urandom_range(0, 15) == 0);
		return it;
	endfunction

	// Offer one byte and queue its expected output once it is taken
	task automatic send_item(input item_t it, input logic typed, input logic [7:0] want);
		result_t r;
		int      g;
		int      k;
		g = pick_gap(sender_steady);
		@(negedge clk);
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		format_byte(it);
		if (typed) begin
			r.out_byte = want;
			r.last_of_run = 1'b1;
			expected_out.push_back(r);
		end else begin
			for (k = 0; k < formatted.size(); k++) begin
				r.out_byte = formatted[k];
				r.last_of_run = (k == formatted.size() - 1);
				expected_out.push_back(r);
			end
		end
		n_items++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Drain the block, then write every option register
	task automatic set_options(input cfg_t c);
		@(negedge clk);
		push <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(REG_NUMBER_ALL, c.number_all_lines);
		write_reg(REG_NUMBER_NONBLANK, c.number_nonblank_lines);
		write_reg(REG_SHOW_ENDS, c.show_line_ends);
		write_reg(REG_SHOW_TABS, c.show_tabs);
		write_reg(REG_SHOW_NONPRINT, c.show_nonprinting);
		write_reg(REG_SQUEEZE, c.squeeze_blank);
		@(negedge clk);
		cfg_valid <= 1'b0;
		pred_opts = c;
		n_settings++;
	endtask

	// Result side: pop with random gaps, check each transaction in order
	initial begin
		result_t exp_r;
		int      g;
		pop = 1'b0;
		receiver_steady = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			g = pick_gap(receiver_steady);
			@(negedge clk);
			if (g > 0) begin
				pop <= 1'b0;
				repeat (g) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			n_results++;
			if (expected_out.size() == 0) begin
				errors++;
				$display("%0t: expected no result, got byte %02h last %0b", $time,
					result.out_byte, result.last_of_run);
			end else begin
				exp_r = expected_out.pop_front();
				if (result.out_byte !== exp_r.out_byte) begin
					errors++;
					$display("%0t: out_byte expected %02h, got %02h", $time,
						exp_r.out_byte, result.out_byte);
				end
				if (result.last_of_run !== exp_r.last_of_run) begin
					errors++;
					$display("%0t: last_of_run expected %0b, got %0b", $time,
						exp_r.last_of_run, result.last_of_run);
				end
			end
			if (n_results % 40 == 0)
				receiver_steady = ($urandom_range(0, 2) == 0);
			// Hold off long enough for the block to fill and stall its input
			if (hold_wanted) begin
				hold_wanted = 1'b0;
				@(negedge clk);
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
		end
	end

	// End the run when no transaction of any kind moves for too long
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		cfg_t       opts;
		stim_row_t  row;
		int         p;
		int         k;
		int         nl_pct;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_NUMBER_ALL;
		cfg_data = 1'b0;
		errors = 0;
		n_items = 0;
		n_results = 0;
		n_settings = 0;
		stall_cycles = 0;
		sender_steady = 1'b0;
		hold_wanted = 1'b0;
		pred_line_bcd = '0;
		pred_at_line_start = 1'b1;
		pred_nl_run = 2'd1;
		pred_opts = C_PLAIN;

		// Directed table: options, byte, file_start, typed, expected byte
		// Plain options after reset: every byte passes through unchanged
		dir_rows.push_back({C_PLAIN, 8'h41, 1'b1, 1'b1, 8'h41});
		dir_rows.push_back({C_PLAIN, 8'h00, 1'b0, 1'b1, 8'h00});
		dir_rows.push_back({C_PLAIN, 8'hFF, 1'b0, 1'b1, 8'hFF});
		dir_rows.push_back({C_PLAIN, CH_TAB, 1'b0, 1'b1, CH_TAB});
		dir_rows.push_back({C_PLAIN, CH_NL, 1'b0, 1'b1, CH_NL});
		// Everything visible, squeezing on; first row is the longest expansion
		dir_rows.push_back({C_SHOW, 8'hFF, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back({C_SHOW, 8'h00, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back({C_SHOW, 8'h7F, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back({C_SHOW, 8'h80, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back({C_SHOW, 8'hA0, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back({C_SHOW, CH_TAB, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back({C_SHOW, CH_NL, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back({C_SHOW, CH_NL, 1'b0, 1'b0, 8'h00});
		// Third newline in a row is dropped, a file start restarts the run
		dir_rows.push_back({C_SHOW, CH_NL, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back({C_SHOW, CH_NL, 1'b1, 1'b0, 8'h00});
		dir_rows.push_back({C_SHOW, 8'h78, 1'b0, 1'b0, 8'h00});
		// File starting mid-line gets no number
		dir_rows.push_back({C_SHOW, 8'h79, 1'b1, 1'b0, 8'h00});
		dir_rows.push_back({C_SHOW, 8'h1F, 1'b0, 1'b0, 8'h00});
		// Non-blank numbering wins; blank lines kept with squeezing off
		dir_rows.push_back({C_NONBLANK, CH_NL, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back({C_NONBLANK, CH_NL, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back({C_NONBLANK, CH_NL, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back({C_NONBLANK, 8'h7A, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back({C_NONBLANK, 8'h89, 1'b0, 1'b0, 8'h00});
		dir_rows.push_back({C_NONBLANK, CH_NL, 1'b0, 1'b0, 8'h00});

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.opts != pred_opts)
				set_options(row.opts);
			send_item(row.stim, row.typed, row.want);
		end

		// Random phases, each under its own option setting
		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: opts = C_ALL_ON;
				1: opts = C_PLAIN;
				2: opts = C_COUNT;
				default: opts = cfg_t'(6'($urandom_range(0, 63)));
			endcase
			nl_pct = (p == 2) ? 55 : 18;
			set_options(opts);
			sender_steady = ($urandom_range(0, 3) == 0);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 3 && k == 4)
					hold_wanted = 1'b1;
				send_item(random_text_byte(nl_pct), 1'b0, 8'h00);
			end
		end

		// Drain and let any trailing work settle
		@(negedge clk);
		push <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d input bytes under %0d option settings, checked %0d output bytes.",
			n_items, n_settings, n_results);
		$display("Line counter ended at %0h; %0d mismatches.", pred_line_bcd, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
